### rtl/pwem_pkg.sv
// Package for the peak window energy meter: shared word types, register
// indexes and reset values of the configuration registers.
// No dependencies.
package pwem_pkg;

    localparam int PEAK_W   = 17;
    localparam int TIME_W   = 32;
    localparam int ENERGY_W = 48;
    localparam int POWER_W  = 32;
    localparam int CFG_W    = 32;
    localparam int IDX_W    = 2;

    localparam logic [IDX_W-1:0] REG_ON_THRESHOLD  = 2'd0;
    localparam logic [IDX_W-1:0] REG_CHANGE_MARGIN = 2'd1;
    localparam logic [IDX_W-1:0] REG_POWER_GAIN    = 2'd2;

    localparam logic [15:0] ON_THRESHOLD_RST  = 16'd100;
    localparam logic [15:0] CHANGE_MARGIN_RST = 16'd10;
    localparam logic [31:0] POWER_GAIN_RST    = 32'd65536;

    // Command word from the front to the back: a settle-and-report request,
    // a window close, or both.
    typedef struct packed {
        logic                 rc;
        logic                 close;
        logic [PEAK_W-1:0]    peak;
        logic [TIME_W-1:0]    time_ms;
    } cmd_t;

    typedef struct packed {
        logic [ENERGY_W-1:0]  energy;
        logic                 load_on;
        logic [POWER_W-1:0]   power;
    } res_t;

    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     index;
        logic [CFG_W-1:0]     data;
    } cfg_wr_t;

endpackage

### rtl/pwem_fifo.sv
// Small register queue used between the front and the back and for results.
// Generic; no package needed.
module pwem_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/pwem_front.sv
// Front of the meter: takes samples, keeps the running window peak and count,
// and issues a command word for report requests and window closes.
// Depends on pwem_pkg.
module pwem_front
    import pwem_pkg::*;
#(
    parameter int WINDOW_SAMPLES = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic signed [15:0] sample,
    input  logic [31:0]        time_ms,
    input  logic               read_clear,
    output logic               cmd_push,
    output cmd_t               cmd
);

    localparam int CNT_W = $clog2(WINDOW_SAMPLES);

    logic [PEAK_W-1:0] peak_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PEAK_W-1:0] mag;
    logic [PEAK_W-1:0] peak_new;
    logic              close;

    // Two's complement magnitude; the most negative code gives 32768.
    assign mag      = sample[15] ? (~{1'b1, sample} + 1'b1) : {1'b0, sample};
    assign peak_new = (mag > peak_reg) ? mag : peak_reg;
    assign close    = (count_reg == CNT_W'(WINDOW_SAMPLES - 1));

    assign cmd_push      = accept && (read_clear || close);
    assign cmd.rc        = read_clear;
    assign cmd.close     = close;
    assign cmd.peak      = peak_new;
    assign cmd.time_ms   = time_ms;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg  <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            if (close)
            begin
                peak_reg  <= '0;
                count_reg <= '0;
            end
            else
            begin
                peak_reg  <= peak_new;
                count_reg <= count_reg + 1'b1;
            end
        end
    end

endmodule

### rtl/pwem_back.sv
// Back of the meter: sequencer that settles energy, tracks the load state and
// updates the power value, sharing one 32x32 multiplier. Holds the config.
// Depends on pwem_pkg.
module pwem_back
    import pwem_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_wr_t cfg,
    input  cmd_t    cmd_data,
    input  logic    cmd_empty,
    output logic    cmd_pop,
    input  logic    res_full,
    output logic    res_push,
    output res_t    res_data
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SET_MUL = 6'b000010,
        ST_SET_ACC = 6'b000100,
        ST_WIN     = 6'b001000,
        ST_PWR_MUL = 6'b010000,
        ST_PWR_SAT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0]         on_threshold_reg;
    logic [15:0]         change_margin_reg;
    logic [31:0]         power_gain_reg;

    cmd_t                cmd_reg;
    logic                rc_phase_reg;
    logic [PEAK_W-1:0]   prev_peak_reg;
    logic                is_on_reg;
    logic [TIME_W-1:0]   start_reg, end_reg;
    logic [POWER_W-1:0]  power_reg;
    logic [ENERGY_W-1:0] energy_reg;
    logic [63:0]         prod_reg;

    logic [31:0]         mul_a, mul_b;
    logic [63:0]         mul_prod;
    logic [TIME_W-1:0]   dur;
    logic [ENERGY_W:0]   sum;
    logic [ENERGY_W-1:0] energy_sat;
    logic [PEAK_W-1:0]   diff;
    logic                above;

    assign dur   = (is_on_reg ? cmd_reg.time_ms : end_reg) - start_reg;
    assign above = cmd_reg.peak > {1'b0, on_threshold_reg};
    assign diff  = (cmd_reg.peak >= prev_peak_reg) ? cmd_reg.peak - prev_peak_reg
                                                   : prev_peak_reg - cmd_reg.peak;

    // The one multiplier: on-time times power, or peak times gain.
    always_comb
    begin
        if (state_reg == ST_PWR_MUL)
        begin
            mul_a = {{(32 - PEAK_W){1'b0}}, cmd_reg.peak};
            mul_b = power_gain_reg;
        end
        else
        begin
            mul_a = dur;
            mul_b = power_reg;
        end
    end
    assign mul_prod = mul_a * mul_b;

    assign sum        = {1'b0, energy_reg} + {1'b0, prod_reg[ENERGY_W-1:0]};
    assign energy_sat = ((prod_reg[63:ENERGY_W] != '0) || sum[ENERGY_W]) ? '1
                                                                        : sum[ENERGY_W-1:0];

    assign res_push         = (state_reg == ST_SET_ACC) && rc_phase_reg;
    assign res_data.energy  = energy_sat;
    assign res_data.load_on = is_on_reg;
    assign res_data.power   = power_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // A report needs room in the result queue before it starts.
                if (!cmd_empty && (!cmd_data.rc || !res_full))
                begin
                    cmd_pop    = 1'b1;
                    state_next = cmd_data.rc ? ST_SET_MUL : ST_WIN;
                end
            end
            ST_SET_MUL:
            begin
                state_next = ST_SET_ACC;
            end
            ST_SET_ACC:
            begin
                if (rc_phase_reg)
                begin
                    state_next = cmd_reg.close ? ST_WIN : ST_IDLE;
                end
                else
                begin
                    state_next = ST_PWR_MUL;
                end
            end
            ST_WIN:
            begin
                state_next = (diff >= {1'b0, change_margin_reg}) ? ST_SET_MUL : ST_PWR_MUL;
            end
            ST_PWR_MUL:
            begin
                state_next = ST_PWR_SAT;
            end
            ST_PWR_SAT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd_data;
        end
        if ((state_reg == ST_SET_MUL) || (state_reg == ST_PWR_MUL))
        begin
            prod_reg <= mul_prod;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            on_threshold_reg  <= ON_THRESHOLD_RST;
            change_margin_reg <= CHANGE_MARGIN_RST;
            power_gain_reg    <= POWER_GAIN_RST;
            rc_phase_reg      <= 1'b0;
            prev_peak_reg     <= '0;
            is_on_reg         <= 1'b0;
            start_reg         <= '0;
            end_reg           <= '0;
            power_reg         <= '0;
            energy_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.en)
            begin
                case (cfg.index)
                    REG_ON_THRESHOLD:  on_threshold_reg  <= cfg.data[15:0];
                    REG_CHANGE_MARGIN: change_margin_reg <= cfg.data[15:0];
                    REG_POWER_GAIN:    power_gain_reg    <= cfg.data;
                    default:           ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_pop)
                    begin
                        rc_phase_reg <= cmd_data.rc;
                    end
                end
                ST_SET_MUL:
                begin
                    start_reg <= cmd_reg.time_ms;
                    end_reg   <= cmd_reg.time_ms;
                end
                ST_SET_ACC:
                begin
                    if (rc_phase_reg)
                    begin
                        energy_reg   <= '0;
                        rc_phase_reg <= 1'b0;
                    end
                    else
                    begin
                        energy_reg <= energy_sat;
                    end
                end
                ST_WIN:
                begin
                    if (above && !is_on_reg)
                    begin
                        is_on_reg <= 1'b1;
                        start_reg <= cmd_reg.time_ms;
                    end
                    else if (!above && is_on_reg)
                    begin
                        is_on_reg <= 1'b0;
                        end_reg   <= cmd_reg.time_ms;
                    end
                end
                ST_PWR_MUL:
                begin
                    prev_peak_reg <= cmd_reg.peak;
                end
                ST_PWR_SAT:
                begin
                    power_reg <= (prod_reg[63:POWER_W] != '0) ? '1 : prod_reg[POWER_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

### rtl/peak_window_energy_meter_unit.sv
// Report words go through the command queue and the back to the result queue. The
// front takes one word per cycle while the command queue has room. The back takes one
// command at a time: SET_MUL, SET_ACC if it asks a report; then, if it closes the
// window, WIN, SET_MUL/SET_ACC if the peak moved by >= the margin, PWR_MUL, PWR_SAT.
// Reset (rst_n, asynchronous, active low) clears queues and all meter state
// and loads the registers with their default values.
module peak_window_energy_meter_unit
    import pwem_pkg::*;
#(
    parameter int WINDOW_SAMPLES = 15,
    parameter int CMD_DEPTH      = 4,
    parameter int RES_DEPTH      = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] sample,
    input  logic [31:0]        time_ms,
    input  logic               read_clear,
    output logic               empty,
    input  logic               pop,
    output logic [47:0]        energy,
    output logic               load_on,
    output logic [31:0]        power,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    cmd_t    cmd_in, cmd_out;
    res_t    res_in, res_out;
    cfg_wr_t cfg;
    logic    cmd_push, cmd_pop, cmd_empty;
    logic    res_push, res_full;

    assign cfg.en    = cfg_wr_en;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    pwem_front #(
        .WINDOW_SAMPLES(WINDOW_SAMPLES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (push && !full),
        .sample    (sample),
        .time_ms   (time_ms),
        .read_clear(read_clear),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    pwem_fifo #(
        .WIDTH($bits(cmd_t)),
        .DEPTH(CMD_DEPTH)
    ) u_cmd_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (cmd_push),
        .wdata(cmd_in),
        .full (full),
        .pop  (cmd_pop),
        .rdata(cmd_out),
        .empty(cmd_empty)
    );

    pwem_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd_data (cmd_out),
        .cmd_empty(cmd_empty),
        .cmd_pop  (cmd_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_data (res_in)
    );

    pwem_fifo #(
        .WIDTH($bits(res_t)),
        .DEPTH(RES_DEPTH)
    ) u_res_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (res_push),
        .wdata(res_in),
        .full (res_full),
        .pop  (pop),
        .rdata(res_out),
        .empty(empty)
    );

    assign energy  = res_out.energy;
    assign load_on = res_out.load_on;
    assign power   = res_out.power;

endmodule

### rtl/pwem_checker.sv
// Port-level checker for the peak window energy meter, bound to the top level.
// Depends only on the top level's ports.
module pwem_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        read_clear,
    input logic        empty,
    input logic        pop,
    input logic [47:0] energy,
    input logic        load_on,
    input logic [31:0] power
);

    logic [15:0] pending_reg;
    logic        req_acc, res_acc;

    assign req_acc = push && !full && read_clear;
    assign res_acc = pop && !empty;

    // Reports requested but not yet taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (req_acc && !res_acc)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (res_acc && !req_acc)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    // Checked only once reset has been held low across a clock edge, so the queues have cleared.
    a_reset_clear: assert property (@(posedge clk) (!rst_n ##1 !rst_n) |-> (empty && !full))
        else $error("queues not cleared by reset");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (pending_reg != 16'd0))
        else $error("result word shown without a pending report request");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(energy) && $stable(load_on)
                              && $stable(power)))
        else $error("waiting result word changed before it was taken");

endmodule

bind peak_window_energy_meter_unit pwem_checker u_pwem_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .read_clear(read_clear),
    .empty     (empty),
    .pop       (pop),
    .energy    (energy),
    .load_on   (load_on),
    .power     (power)
);
